// File: hw/rtl/ows_pkg.sv
// Shared types, codes and the serial CRC-8 step for the 1-Wire search-ROM engine.
// Used by ows_step and onewire_rom_search_engine; depends on nothing else.
package ows_pkg;

    localparam int ROM_BITS = 64;
    localparam int POS_BITS = 7;
    localparam int CRC_BITS = 8;

    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_NEXT  = 2'd1;
    localparam logic [1:0] MODE_BIT   = 2'd2;

    localparam logic [CRC_BITS-1:0] CRC_FEEDBACK = 8'h18;
    localparam logic [CRC_BITS-1:0] CRC_TOP      = 8'h80;
    localparam logic [POS_BITS-1:0] END_POSITION = 7'd65;

    typedef enum logic [2:0] {
        ST_BIT_SENT    = 3'd0,
        ST_STARTED     = 3'd1,
        ST_NO_DEVICE   = 3'd2,
        ST_NO_RESPONSE = 3'd3,
        ST_CRC_ERROR   = 3'd4,
        ST_FOUND       = 3'd5,
        ST_IGNORED     = 3'd6
    } status_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       no_presence;
        logic       id_bit;
        logic       complement_bit;
    } item_t;

    typedef struct packed {
        logic [ROM_BITS-1:0] rom;
        logic [POS_BITS-1:0] last_disc;
        logic [POS_BITS-1:0] zero_pos;
        logic                last_found;
        logic [POS_BITS-1:0] bit_pos;
        logic [CRC_BITS-1:0] crc;
        logic                active;
    } search_state_t;

    typedef struct packed {
        status_t             status;
        logic                direction;
        logic [ROM_BITS-1:0] rom_code;
        logic [CRC_BITS-1:0] crc_value;
        logic [POS_BITS-1:0] last_discrepancy;
    } result_t;

    // One shift of the reflected x^8+x^5+x^4+1 CRC.
    function automatic logic [CRC_BITS-1:0] crc8_step(input logic [CRC_BITS-1:0] crc,
                                                      input logic din);
        logic [CRC_BITS-1:0] fb;
        fb = crc ^ CRC_FEEDBACK;
        if (crc[0] ^ din)
        begin
            return (fb >> 1) | CRC_TOP;
        end
        return crc >> 1;
    endfunction

endpackage

// File: hw/rtl/ows_step.sv
// Combinational search step: next search state and result beat for one item.
// Depends on ows_pkg.
module ows_step
    import ows_pkg::*;
(
    input  item_t         item,
    input  search_state_t state_cur,
    output search_state_t state_next,
    output result_t       result
);

    logic [5:0]          idx;
    logic                dir;
    logic [CRC_BITS-1:0] crc_new;
    logic [POS_BITS-1:0] pos_new;
    status_t             status;

    always_comb
    begin
        state_next = state_cur;
        status     = ST_IGNORED;
        dir        = 1'b0;
        idx        = 6'(state_cur.bit_pos - 7'd1);
        crc_new    = '0;
        pos_new    = '0;

        unique case (item.mode)
            MODE_FIRST, MODE_NEXT:
            begin
                if (item.mode == MODE_FIRST)
                begin
                    state_next.last_disc  = '0;
                    state_next.last_found = 1'b0;
                end
                state_next.crc = '0;
                // A first search has already dropped the found flag above.
                if (item.no_presence || state_next.last_found)
                begin
                    state_next.last_disc  = '0;
                    state_next.last_found = 1'b0;
                    state_next.active     = 1'b0;
                    status                = ST_NO_DEVICE;
                end
                else
                begin
                    state_next.bit_pos  = 7'd1;
                    state_next.zero_pos = '0;
                    state_next.active   = 1'b1;
                    status              = ST_STARTED;
                end
            end
            MODE_BIT:
            begin
                if (state_cur.active)
                begin
                    if (item.id_bit && item.complement_bit)
                    begin
                        state_next.last_disc  = '0;
                        state_next.last_found = 1'b0;
                        state_next.active     = 1'b0;
                        status                = ST_NO_RESPONSE;
                    end
                    else
                    begin
                        if (!item.id_bit && !item.complement_bit)
                        begin
                            // Devices with both bit values answer: follow the discrepancy rules.
                            if (state_cur.bit_pos == state_cur.last_disc)
                            begin
                                dir = 1'b1;
                            end
                            else if (state_cur.bit_pos > state_cur.last_disc)
                            begin
                                dir = 1'b0;
                            end
                            else
                            begin
                                dir = state_cur.rom[idx];
                            end
                            if (!dir)
                            begin
                                state_next.zero_pos = state_cur.bit_pos;
                            end
                        end
                        else
                        begin
                            dir = item.id_bit;
                        end
                        state_next.rom[idx] = dir;
                        crc_new             = crc8_step(state_cur.crc, dir);
                        pos_new             = state_cur.bit_pos + 7'd1;
                        state_next.crc      = crc_new;
                        state_next.bit_pos  = pos_new;
                        status              = ST_BIT_SENT;
                        if (pos_new >= END_POSITION)
                        begin
                            state_next.active = 1'b0;
                            if (crc_new != '0)
                            begin
                                state_next.last_disc  = '0;
                                state_next.last_found = 1'b0;
                                status                = ST_CRC_ERROR;
                            end
                            else
                            begin
                                state_next.last_disc = state_next.zero_pos;
                                if (state_next.zero_pos == '0)
                                begin
                                    state_next.last_found = 1'b1;
                                end
                                status = ST_FOUND;
                            end
                        end
                    end
                end
            end
            default:
            begin
                status = ST_IGNORED;
            end
        endcase

        result.status           = status;
        result.direction        = dir;
        result.rom_code         = state_next.rom;
        result.crc_value        = state_next.crc;
        result.last_discrepancy = state_next.last_disc;
    end

endmodule

// File: hw/rtl/onewire_rom_search_engine.sv
// Top level of the 1-Wire search-ROM engine: input register, search state,
// result register. Depends on ows_pkg and ows_step.
//
//  port group | role   | tuser (low bit up)  | tdata (low bit up)
//  s_*        | items  | mode[1:0]           | no_presence, id_bit, complement_bit, 5 zeros
//  m_*        | result | status[2:0]         | direction, rom_code[63:0], crc_value[7:0],
//             |        |                     | last_discrepancy[6:0]
//
// One item per cycle is sustained while m_tready keeps the result register draining; each
// input beat is held in the input register, and its result is written to the result register
// together with the single search-state update between the two.
// Reset clears the search state and both valid flags, with no clearing pass.
// A stalled result holds in the output register while one more input beat is taken.
module onewire_rom_search_engine
    import ows_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // no_presence, id_bit, complement_bit, zero fill
    input  logic [1:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // direction, rom_code, crc_value, last_discrepancy
    output logic [2:0]  m_tuser    // status
);

    logic          in_valid_reg;
    item_t         in_item_reg;
    logic          out_valid_reg;
    result_t       out_result_reg;
    search_state_t state_reg;
    search_state_t state_next;
    result_t       result_next;
    logic          advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    ows_step u_step (
        .item       (in_item_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.mode           <= s_tuser;
            in_item_reg.no_presence    <= s_tdata[0];
            in_item_reg.id_bit         <= s_tdata[1];
            in_item_reg.complement_bit <= s_tdata[2];
        end
        if (advance)
        begin
            out_result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.status;
    assign m_tdata  = {out_result_reg.last_discrepancy, out_result_reg.crc_value,
                       out_result_reg.rom_code, out_result_reg.direction};

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for onewire_rom_search_engine: a directed table, then searches
// over simulated device populations on a wired-AND bus, checked against an in-bench model.
// Depends on ows_pkg and the engine RTL only.
module tb_top;
    import ows_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam logic [7:0] CRC_POLY_REFL = 8'h8C;
    localparam int RANDOM_BEATS  = 1650;
    localparam int DIRECTED_ROWS = 21;
    localparam int TOTAL_BEATS   = RANDOM_BEATS + DIRECTED_ROWS;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;

    localparam result_t IDLE_IGNORED     = {ST_IGNORED, 1'b0, 64'h0, 8'h0, 7'd0};
    localparam result_t IDLE_NO_DEVICE   = {ST_NO_DEVICE, 1'b0, 64'h0, 8'h0, 7'd0};
    localparam result_t IDLE_STARTED     = {ST_STARTED, 1'b0, 64'h0, 8'h0, 7'd0};
    localparam result_t IDLE_NO_RESPONSE = {ST_NO_RESPONSE, 1'b0, 64'h0, 8'h0, 7'd0};
    localparam result_t NOT_TYPED        = '0;

    typedef struct packed {
        logic [1:0] mode;
        logic       no_presence;
        logic       id_bit;
        logic       complement_bit;
        logic       typed;
        result_t    result;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h0;
    logic [1:0]  s_tuser = MODE_FIRST;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [2:0]  m_tuser;

    // Search state as the engine should hold it.
    logic [63:0] exp_rom = '0;
    logic [6:0]  exp_last_disc = '0;
    logic [6:0]  exp_zero_pos = '0;
    logic        exp_last_found = 1'b0;
    logic [6:0]  exp_bit_pos = '0;
    logic [7:0]  exp_crc = '0;
    logic        exp_active = 1'b0;

    result_t     search_results_q[$];
    logic [63:0] bus_devices[$];
    int          beats_sent = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          tx_idle_pct = 30;
    int          rx_idle_pct = 73;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        {MODE_BIT,    1'b0, 1'b1, 1'b0, 1'b1, IDLE_IGNORED},
        {MODE_UNUSED, 1'b1, 1'b1, 1'b1, 1'b1, IDLE_IGNORED},
        {MODE_FIRST,  1'b1, 1'b0, 1'b0, 1'b1, IDLE_NO_DEVICE},
        {MODE_NEXT,   1'b1, 1'b1, 1'b1, 1'b1, IDLE_NO_DEVICE},
        {MODE_FIRST,  1'b0, 1'b0, 1'b0, 1'b1, IDLE_STARTED},
        {MODE_BIT,    1'b0, 1'b1, 1'b1, 1'b1, IDLE_NO_RESPONSE},
        {MODE_BIT,    1'b0, 1'b0, 1'b0, 1'b1, IDLE_IGNORED},
        {MODE_NEXT,   1'b0, 1'b0, 1'b0, 1'b1, IDLE_STARTED},
        {MODE_BIT,    1'b0, 1'b1, 1'b0, 1'b0, NOT_TYPED},
        {MODE_BIT,    1'b1, 1'b0, 1'b1, 1'b0, NOT_TYPED},
        {MODE_BIT,    1'b0, 1'b0, 1'b0, 1'b0, NOT_TYPED},
        {MODE_BIT,    1'b0, 1'b1, 1'b0, 1'b0, NOT_TYPED},
        // A new start while a pass is running abandons that pass.
        {MODE_FIRST,  1'b0, 1'b1, 1'b1, 1'b0, NOT_TYPED},
        {MODE_BIT,    1'b0, 1'b0, 1'b0, 1'b0, NOT_TYPED},
        {MODE_UNUSED, 1'b0, 1'b0, 1'b0, 1'b0, NOT_TYPED},
        {MODE_BIT,    1'b1, 1'b1, 1'b0, 1'b0, NOT_TYPED},
        {MODE_BIT,    1'b0, 1'b1, 1'b1, 1'b0, NOT_TYPED},
        {MODE_NEXT,   1'b0, 1'b0, 1'b0, 1'b0, NOT_TYPED},
        {MODE_BIT,    1'b0, 1'b0, 1'b1, 1'b0, NOT_TYPED},
        {MODE_NEXT,   1'b1, 1'b0, 1'b0, 1'b0, NOT_TYPED},
        {MODE_BIT,    1'b0, 1'b0, 1'b0, 1'b0, NOT_TYPED}
    };

    onewire_rom_search_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [7:0] crc8_shift(input logic [7:0] crc, input logic din);
        return (crc >> 1) ^ ((crc[0] ^ din) ? CRC_POLY_REFL : 8'h00);
    endfunction

    // Advances the expected search state by one beat and returns the result it must produce.
    function automatic result_t search_predict(input logic [1:0] mode, input logic no_presence,
                                               input logic id_bit, input logic cmp_bit);
        result_t    r;
        logic       dir;
        logic [5:0] idx;
        r.status = ST_IGNORED;
        dir = 1'b0;
        if (mode == MODE_FIRST || mode == MODE_NEXT)
        begin
            if (mode == MODE_FIRST)
            begin
                exp_last_disc = '0;
                exp_last_found = 1'b0;
            end
            exp_crc = '0;
            if (no_presence || exp_last_found)
            begin
                exp_last_disc = '0;
                exp_last_found = 1'b0;
                exp_active = 1'b0;
                r.status = ST_NO_DEVICE;
            end
            else
            begin
                exp_bit_pos = 7'd1;
                exp_zero_pos = '0;
                exp_active = 1'b1;
                r.status = ST_STARTED;
            end
        end
        else if (mode == MODE_BIT && exp_active)
        begin
            if (id_bit && cmp_bit)
            begin
                exp_last_disc = '0;
                exp_last_found = 1'b0;
                exp_active = 1'b0;
                r.status = ST_NO_RESPONSE;
            end
            else
            begin
                idx = 6'(exp_bit_pos - 7'd1);
                if (!id_bit && !cmp_bit)
                begin
                    // Both values present on the bus: the discrepancy rules pick the branch.
                    if (exp_bit_pos == exp_last_disc)
                        dir = 1'b1;
                    else if (exp_bit_pos > exp_last_disc)
                        dir = 1'b0;
                    else
                        dir = exp_rom[idx];
                    if (!dir)
                        exp_zero_pos = exp_bit_pos;
                end
                else
                begin
                    dir = id_bit;
                end
                exp_rom[idx] = dir;
                exp_crc = crc8_shift(exp_crc, dir);
                exp_bit_pos = exp_bit_pos + 7'd1;
                r.status = ST_BIT_SENT;
                if (exp_bit_pos >= END_POSITION)
                begin
                    exp_active = 1'b0;
                    if (exp_crc != 8'h00)
                    begin
                        exp_last_disc = '0;
                        exp_last_found = 1'b0;
                        r.status = ST_CRC_ERROR;
                    end
                    else
                    begin
                        exp_last_disc = exp_zero_pos;
                        if (exp_last_disc == 7'd0)
                            exp_last_found = 1'b1;
                        r.status = ST_FOUND;
                    end
                end
            end
        end
        r.direction = dir;
        r.rom_code = exp_rom;
        r.crc_value = exp_crc;
        r.last_discrepancy = exp_last_disc;
        return r;
    endfunction

    task automatic send_beat(input logic [1:0] mode, input logic no_presence,
                             input logic id_bit, input logic cmp_bit, output result_t pred);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {5'b0, cmp_bit, id_bit, no_presence};
        do
            @(posedge clk);
        while (!s_tready);
        pred = search_predict(mode, no_presence, id_bit, cmp_bit);
        search_results_q.push_back(pred);
        beats_sent++;
        if (beats_sent < TOTAL_BEATS / 3)
        begin
            tx_idle_pct = 30;
            rx_idle_pct = 73;
        end
        else if (beats_sent < 2 * TOTAL_BEATS / 3)
        begin
            tx_idle_pct = 73;
            rx_idle_pct = 30;
        end
        else
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (search_results_q.size() != 0);
    endtask

    // Devices share a random body with a few flipped bits, so the search tree branches
    // at scattered depths. Now and then a check byte is corrupted.
    task automatic make_population(input int count);
        logic [55:0] base;
        logic [55:0] body;
        logic [7:0]  crc;
        int          k;
        int          j;
        int          flip;
        bus_devices.delete();
        base = 56'({$urandom(), $urandom()});
        for (k = 0; k < count; k++)
        begin
            body = base;
            repeat ($urandom_range(1, 4))
            begin
                flip = $urandom_range(0, 55);
                body[flip] = ~body[flip];
            end
            crc = 8'h00;
            for (j = 0; j < 56; j++)
                crc = crc8_shift(crc, body[j]);
            if ($urandom_range(0, 11) == 0)
            begin
                flip = $urandom_range(0, 7);
                crc[flip] = ~crc[flip];
            end
            bus_devices.push_back({crc, body});
        end
    endtask

    // Plays the bus for up to bit_count bit pairs: the reads are the wired-AND of the
    // devices still selected, which then drop out if the engine writes the other value.
    task automatic run_pass(input int bit_count);
        int      alive;
        int      b;
        int      k;
        logic    id_bit;
        logic    cmp_bit;
        result_t pred;
        alive = (1 << bus_devices.size()) - 1;
        for (b = 0; b < bit_count; b++)
        begin
            id_bit = 1'b1;
            cmp_bit = 1'b1;
            for (k = 0; k < bus_devices.size(); k++)
            begin
                if (alive[k])
                begin
                    if (bus_devices[k][b])
                        cmp_bit = 1'b0;
                    else
                        id_bit = 1'b0;
                end
            end
            send_beat(MODE_BIT, 1'($urandom_range(0, 1)), id_bit, cmp_bit, pred);
            if (pred.status != ST_BIT_SENT)
                break;
            for (k = 0; k < bus_devices.size(); k++)
            begin
                if (bus_devices[k][b] != pred.direction)
                    alive[k] = 0;
            end
        end
    endtask

    task automatic run_enumeration();
        int         passes;
        logic [1:0] mode;
        result_t    pred;
        make_population($urandom_range(1, 4));
        mode = MODE_FIRST;
        for (passes = 0; passes < bus_devices.size() + 2; passes++)
        begin
            send_beat(mode, ($urandom_range(0, 19) == 0), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), pred);
            mode = MODE_NEXT;
            if (pred.status != ST_STARTED)
                break;
            run_pass(64);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (search_results_q.size() == 0)
            begin
                $error("result beat with nothing expected: status %0d", m_tuser);
                mismatch_count++;
            end
            else
            begin
                want = search_results_q.pop_front();
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[0] !== want.direction)
                begin
                    $error("direction: expected %0d, got %0d", want.direction, m_tdata[0]);
                    mismatch_count++;
                end
                if (m_tdata[64:1] !== want.rom_code)
                begin
                    $error("rom_code: expected %h, got %h", want.rom_code, m_tdata[64:1]);
                    mismatch_count++;
                end
                if (m_tdata[72:65] !== want.crc_value)
                begin
                    $error("crc_value: expected %h, got %h", want.crc_value, m_tdata[72:65]);
                    mismatch_count++;
                end
                if (m_tdata[79:73] !== want.last_discrepancy)
                begin
                    $error("last_discrepancy: expected %0d, got %0d",
                           want.last_discrepancy, m_tdata[79:73]);
                    mismatch_count++;
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        int        r;
        int        pick;
        result_t   pred;
        stim_row_t row;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < DIRECTED_ROWS; r++)
        begin
            row = directed_rows[r];
            send_beat(row.mode, row.no_presence, row.id_bit, row.complement_bit, pred);
            if (row.typed)
                search_results_q[search_results_q.size() - 1] = row.result;
        end

        // Hold the sender off until the pipeline has fully emptied once.
        wait_results_drained();

        while (beats_sent < TOTAL_BEATS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                run_enumeration();
            end
            else if (pick < 85)
            begin
                // A pass cut short, or run against an empty bus.
                make_population($urandom_range(0, 3));
                send_beat($urandom_range(0, 1) ? MODE_FIRST : MODE_NEXT, 1'b0,
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pred);
                run_pass($urandom_range(1, 64));
            end
            else
            begin
                repeat ($urandom_range(1, 16))
                    send_beat(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pred);
            end
        end

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
